// ===== hw/rtl/isort_pkg.sv =====
`default_nettype none
package isort_pkg;

    // store depth and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // controller to datapath commands
    typedef struct packed {
        logic             insert;    // write the item value into the insertion chain
        logic             shift;     // move the chain down by one cell towards the head
        logic             load_out;  // take the head cell into the output register
        logic             out_last;  // final result of the batch
        logic             out_ovf;   // batch had dropped items
        logic [CNT_W-1:0] count;     // cells holding data
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== hw/rtl/integer_sorter_unit.sv =====
`default_nettype none
// Sorts a batch of signed 32-bit items held in a 64-cell insertion chain. Every
// cell compares itself with the incoming value, so one item is taken per clock
// while the batch is collected; items that arrive with the chain full are
// dropped and every result of that batch carries o_overflow. The item marked
// last starts the drain: the chain shifts towards its head and delivers one
// result per clock while results are taken, in ascending order, the final one
// with o_last_res. The state register enters the drain after the last item, and
// each result is then loaded into the output register; a result still waiting
// from the previous batch holds the drain back. No item is accepted during the
// drain; once the final result sits in the output register the next batch may
// start while that result waits to be taken.
module integer_sorter_unit
    import isort_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic                     i_last,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_last_res,
    output logic                          o_overflow
);

    t_dp_cmd w_cmd;

    // sequencing and counts
    isort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    // insertion chain and output register
    isort_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_sorted_value (o_sorted_value),
        .o_last_res     (o_last_res),
        .o_overflow     (o_overflow)
    );

    // fill count never passes the chain depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // a drain never reads from an empty chain
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (w_cmd.count != '0))
        else $error("drain with empty chain");

    // the last item stops intake for the drain
    a_last_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> !o_ready)
        else $error("item taken right after last item");

endmodule
`default_nettype wire

// ===== hw/rtl/isort_dp.sv =====
`default_nettype none
module isort_dp
    import isort_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic signed [DATA_W-1:0] i_value,
    output logic signed [DATA_W-1:0]      o_sorted_value,
    output logic                          o_last_res,
    output logic                          o_overflow
);

    logic signed [DATA_W-1:0] r_cell [CAPACITY];
    logic signed [DATA_W-1:0] n_cell [CAPACITY];
    logic [CAPACITY-1:0]      w_above;

    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;

    // per-cell compare: an empty cell counts as above any value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_above[i] = (CNT_W'(i) >= i_cmd.count) || (r_cell[i] > i_value);
        end
    end

    // next chain contents: insert in place, or shift towards the head on drain
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (i_cmd.insert) begin
                if (w_above[i]) begin
                    if (i > 0 && w_above[(i > 0) ? i - 1 : 0]) begin
                        n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_cell[i] = i_value;
                    end
                end
            end else if (i_cmd.shift) begin
                if (i < CAPACITY - 1) begin
                    n_cell[i] = r_cell[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    // chain cells
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value <= r_cell[0];
            r_out_last  <= i_cmd.out_last;
            r_out_ovf   <= i_cmd.out_ovf;
        end
    end

    assign o_sorted_value = r_out_value;
    assign o_last_res     = r_out_last;
    assign o_overflow     = r_out_ovf;

endmodule
`default_nettype wire

// ===== hw/rtl/isort_ctrl.sv =====
`default_nettype none
module isort_ctrl
    import isort_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_last,
    output logic      o_ready,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_dp_cmd   o_cmd
);

    localparam logic ST_COLLECT = 1'b0;
    localparam logic ST_DRAIN   = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_dropped, n_dropped;
    logic             r_out_valid, n_out_valid;

    logic w_in_acc;
    logic w_full;
    logic w_load;

    assign o_ready  = (r_state == ST_COLLECT);
    assign w_in_acc = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_load   = (r_state == ST_DRAIN) && (!r_out_valid || i_ready);

    // sequencing of collect and drain
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_COLLECT: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state   = ST_COLLECT;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd.insert   = w_in_acc && !w_full;
        o_cmd.shift    = w_load;
        o_cmd.load_out = w_load;
        o_cmd.out_last = (r_count == CNT_W'(1));
        o_cmd.out_ovf  = r_dropped;
        o_cmd.count    = r_count;
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire
